@@ src/bfa_pkg.sv @@
package bfa_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = MAX_FRAMES / WORD_BITS;
    localparam int WORD_AW    = $clog2(NUM_WORDS);
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int FRAME_W    = 12;
    localparam int LIMIT_W    = 13;
    localparam int COUNT_W    = WORD_AW + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(MAX_FRAMES);

    // opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_NOFREE = 2'd1;
    localparam logic [1:0] STAT_NOP    = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [FRAME_W-1:0] page_frame;
        logic               is_kernel;
        logic               is_writeable;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame_index;
        logic               present_flag;
        logic               write_flag;
        logic               user_flag;
        logic               frame_used;
    } out_word_t;

    typedef struct packed {
        logic              found;
        logic [BIT_AW-1:0] bit_idx;
    } find_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_TEST,
        S_RESP
    } state_t;

endpackage

@@ src/bfa_ram.sv @@
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/bfa_find.sv @@
module bfa_find (
    input  logic [bfa_pkg::WORD_BITS-1:0] word,
    input  logic [bfa_pkg::LIMIT_W-1:0]   remain,
    output bfa_pkg::find_res_t            res
);

    import bfa_pkg::*;

    logic [WORD_BITS-1:0] free_bits;

    // only bits below the frame limit take part
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            free_bits[j] = !word[j] && (remain > LIMIT_W'(j));
        end
    end

    // lowest free bit
    always_comb
    begin
        res.found   = |free_bits;
        res.bit_idx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (free_bits[j])
            begin
                res.bit_idx = BIT_AW'(j);
            end
        end
    end

endmodule

@@ src/bitmap_frame_allocator.sv @@
// channel  | direction | handshake          | word
// ---------+-----------+--------------------+---------------------------------
// in       | to block  | in_valid/in_stall  | in_data: opcode, frame, flags
// out      | from block| out_valid/out_stall| out_data: status, frame, flags
// cfg      | to block  | cfg_valid/cfg_ready| cfg_data: frame_limit
//
// allocate scans the bitmap one 32-bit word per cycle through a single
// lowest-clear-bit finder; a word is read every cycle until a free bit is
// found or every word below the frame limit has been checked
// free/test go via S_FREE/S_TEST then S_RESP; a no-op word goes to S_RESP
// one word is in flight at a time; in_stall is high until the result has
// been moved to the output register, which may still wait on out_stall
// reset clears the per-row valid bits, so the bitmap reads as all free at once
module bitmap_frame_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bfa_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bfa_pkg::out_word_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfa_pkg::LIMIT_W-1:0]   cfg_data
);

    import bfa_pkg::*;

    state_t                state_reg, state_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic [NUM_WORDS-1:0]  row_valid_reg, row_valid_next;
    logic [COUNT_W-1:0]    word_reg, word_next;       // next word to read in a scan
    logic [WORD_AW-1:0]    chk_word_reg, chk_word_next; // word now on the read port
    logic                  chk_valid_reg, chk_valid_next;
    in_word_t              req_reg, req_next;
    out_word_t             res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_data_reg, out_data_next;

    // ram control
    logic                  ram_we;
    logic [WORD_AW-1:0]    ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_AW-1:0]    ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic [LIMIT_W-1:0]    lim;
    logic [LIMIT_W-1:0]    lim_round;
    logic [COUNT_W-1:0]    num_words;
    logic [LIMIT_W-1:0]    remain;
    logic [WORD_BITS-1:0]  cur_word;
    logic [WORD_BITS-1:0]  bit_mask;
    find_res_t             find_res;
    logic                  in_accept;
    logic                  out_free;
    logic                  scan_done;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // effective limit and number of words to scan
    assign lim       = (limit_reg > LIMIT_MAX) ? LIMIT_MAX : limit_reg;
    assign lim_round = lim + LIMIT_W'(WORD_BITS - 1);
    assign num_words = lim_round[LIMIT_W-1:BIT_AW];
    assign remain    = lim - {chk_word_reg, BIT_AW'(0)};

    // a row never written reads as all free
    assign cur_word  = row_valid_reg[chk_word_reg] ? ram_rdata : '0;

    bfa_find u_find (
        .word   (cur_word),
        .remain (remain),
        .res    (find_res)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_done = !chk_valid_reg && (word_reg >= num_words);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.opcode == OP_ALLOC && in_data.page_frame == '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (in_data.opcode == OP_FREE && in_data.page_frame != '0)
                    begin
                        state_next = S_FREE;
                    end
                    else if (in_data.opcode == OP_TEST)
                    begin
                        state_next = S_TEST;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SCAN:
            begin
                if ((chk_valid_reg && find_res.found) || scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_FREE:  state_next = S_RESP;
            S_TEST:  state_next = S_RESP;
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        limit_next     = limit_reg;
        row_valid_next = row_valid_reg;
        word_next      = word_reg;
        chk_word_next  = chk_word_reg;
        chk_valid_next = 1'b0;
        req_next       = req_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = chk_word_reg;
        ram_wdata      = cur_word;
        ram_raddr      = in_data.page_frame[FRAME_W-1:BIT_AW];
        bit_mask       = '0;

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_next      = in_data;
                    chk_word_next = in_data.page_frame[FRAME_W-1:BIT_AW];
                    word_next     = '0;
                    // nothing to do unless an op below says otherwise
                    res_next              = '0;
                    res_next.status       = STAT_NOP;
                    res_next.frame_index  = in_data.page_frame;
                end
            end
            S_SCAN:
            begin
                ram_raddr = word_reg[WORD_AW-1:0];
                if (chk_valid_reg && find_res.found)
                begin
                    bit_mask                  = WORD_BITS'(1) << find_res.bit_idx;
                    ram_we                    = 1'b1;
                    ram_wdata                 = cur_word | bit_mask;
                    row_valid_next[chk_word_reg] = 1'b1;
                    res_next.status           = STAT_DONE;
                    res_next.frame_index      = {chk_word_reg, find_res.bit_idx};
                    res_next.present_flag     = 1'b1;
                    res_next.write_flag       = req_reg.is_writeable;
                    res_next.user_flag        = !req_reg.is_kernel;
                end
                else if (scan_done)
                begin
                    res_next.status = STAT_NOFREE;
                end
                else
                begin
                    // keep one word read ahead of the finder
                    if (word_reg < num_words)
                    begin
                        chk_word_next  = word_reg[WORD_AW-1:0];
                        chk_valid_next = 1'b1;
                        word_next      = word_reg + COUNT_W'(1);
                    end
                end
            end
            S_FREE:
            begin
                bit_mask                     = WORD_BITS'(1) <<
                                               req_reg.page_frame[BIT_AW-1:0];
                ram_we                       = 1'b1;
                ram_wdata                    = cur_word & ~bit_mask;
                row_valid_next[chk_word_reg] = 1'b1;
                res_next.status              = STAT_DONE;
            end
            S_TEST:
            begin
                res_next.status     = STAT_DONE;
                res_next.frame_used = cur_word[req_reg.page_frame[BIT_AW-1:0]];
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            row_valid_reg <= '0;
            word_reg      <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            row_valid_reg <= row_valid_next;
            word_reg      <= word_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chk_word_reg <= chk_word_next;
        req_reg      <= req_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ src/bfa_checker.sv @@
module bfa_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  bfa_pkg::out_word_t          out_data,
    input  logic                        cfg_ready
);

    import bfa_pkg::*;

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // one word at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word accepted while busy");

    // config is only taken while the block is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !in_stall)
        else $error("config ready while busy");

    // page flags only on a done result, as from a successful allocate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STAT_DONE |->
            !out_data.present_flag && !out_data.write_flag && !out_data.user_flag)
        else $error("flags set on failed or empty op");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.present_flag |->
            out_data.status == STAT_DONE && !out_data.frame_used)
        else $error("allocate result mixed with test result");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);
